### hdl/dtoi_pkg.sv
// ----------------------------------------------------------------------------
// dtoi_pkg
// Types and constants shared by the decimal text to integer converter.
// ----------------------------------------------------------------------------
package dtoi_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] INT_MAX_VAL = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN_VAL = 32'h8000_0000;
    localparam logic [31:0] MAG_TENTH   = INT_MAX_VAL / 32'd10;
    localparam logic [3:0]  POS_LAST_DIGIT = 4'(INT_MAX_VAL % 32'd10);
    localparam logic [3:0]  NEG_LAST_DIGIT = 4'(INT_MIN_VAL % 32'd10);

    typedef enum logic [3:0] {
        PH_SPACES  = 4'b0001,
        PH_SIGN    = 4'b0010,
        PH_DIGITS  = 4'b0100,
        PH_STOPPED = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        OUT_NONE    = 2'd0,
        OUT_PARSED  = 2'd1,
        OUT_CLAMPED = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } char_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        outcome_t           outcome;
    } result_word_t;

endpackage

### hdl/dtoi_char_if.sv
// ----------------------------------------------------------------------------
// dtoi_char_if
// Character channel: valid/ready handshake, one character per word.
// ----------------------------------------------------------------------------
interface dtoi_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

### hdl/dtoi_result_if.sv
// ----------------------------------------------------------------------------
// dtoi_result_if
// Result channel: valid/ready handshake, one parsed integer per word.
// ----------------------------------------------------------------------------
interface dtoi_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         outcome;

    modport source (output valid, output value, output outcome, input ready);
    modport sink   (input valid, input value, input outcome, output ready);
endinterface

### hdl/decimal_text_to_int_saturating_top.sv
// ----------------------------------------------------------------------------
// decimal_text_to_int_saturating_top
// Saturating decimal text to signed 32-bit integer, one character a word.
// ----------------------------------------------------------------------------
//  channel   dir  word                        words out per word in
//  chars     in   char_code[7:0], is_last     -
//  results   out  value[31:0], outcome[1:0]   1 on is_last, else 0
//
//  One character per cycle while no stalled result holds a last character;
//  a result is registered as its last character leaves the input register.
//  The parse update (multiply by ten, add, limit compare) sits between the
//  input register and the result register.
//  rst_n clears the parse state and both valid flags.
//  A stalled result holds only a last character in the input register;
//  other characters keep flowing.
// ----------------------------------------------------------------------------
module decimal_text_to_int_saturating_top (
    input  logic           clk,
    input  logic           rst_n,
    dtoi_char_if.sink      chars,
    dtoi_result_if.source  results
);

    logic                   s1_valid_reg;
    dtoi_pkg::char_word_t   s1_word_reg;
    logic                   out_valid_reg;
    dtoi_pkg::result_word_t out_word_reg;

    logic                   out_free;
    logic                   s1_go;
    logic                   in_take;
    dtoi_pkg::result_word_t res_next;

    assign out_free = !out_valid_reg || results.ready;
    assign s1_go    = s1_valid_reg && (!s1_word_reg.is_last || out_free);
    assign in_take  = chars.valid && chars.ready;

    assign chars.ready     = !s1_valid_reg || s1_go;
    assign results.valid   = out_valid_reg;
    assign results.value   = out_word_reg.value;
    assign results.outcome = out_word_reg.outcome;

    dtoi_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_go),
        .word_in  (s1_word_reg),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go && s1_word_reg.is_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg.char_code <= chars.char_code;
            s1_word_reg.is_last   <= chars.is_last;
        end
        if (s1_go && s1_word_reg.is_last)
        begin
            out_word_reg <= res_next;
        end
    end

endmodule

### hdl/dtoi_parse.sv
// ----------------------------------------------------------------------------
// dtoi_parse
// Parse state and per-character update; forms the result of a string's
// last character.
// ----------------------------------------------------------------------------
module dtoi_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  dtoi_pkg::char_word_t  word_in,
    output dtoi_pkg::result_word_t res_next
);

    dtoi_pkg::phase_t phase_reg, phase_next;
    logic [31:0]      mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             clamped_reg, clamped_next;
    logic             found_reg, found_next;

    logic        is_digit;
    logic [31:0] digit;
    logic [31:0] mag_times_ten;
    logic [3:0]  last_digit;
    logic        overflow;

    assign is_digit      = (word_in.char_code >= dtoi_pkg::CH_ZERO) &&
                           (word_in.char_code <= dtoi_pkg::CH_NINE);
    assign digit         = {28'd0, word_in.char_code[3:0]};
    assign mag_times_ten = {mag_reg[28:0], 3'b000} + {mag_reg[30:0], 1'b0};
    assign last_digit    = neg_reg ? dtoi_pkg::NEG_LAST_DIGIT : dtoi_pkg::POS_LAST_DIGIT;
    assign overflow      = (mag_reg > dtoi_pkg::MAG_TENTH) ||
                           ((mag_reg == dtoi_pkg::MAG_TENTH) &&
                            (word_in.char_code[3:0] > last_digit));

    always_comb
    begin
        phase_next   = phase_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        clamped_next = clamped_reg;
        found_next   = found_reg;
        unique case (phase_reg)
            dtoi_pkg::PH_SPACES:
            begin
                if (word_in.char_code == dtoi_pkg::CH_SPACE)
                begin
                    phase_next = dtoi_pkg::PH_SPACES;
                end
                else if (is_digit)
                begin
                    found_next = 1'b1;
                    mag_next   = digit;
                    phase_next = dtoi_pkg::PH_DIGITS;
                end
                else if ((word_in.char_code == dtoi_pkg::CH_PLUS) ||
                         (word_in.char_code == dtoi_pkg::CH_MINUS))
                begin
                    neg_next   = (word_in.char_code == dtoi_pkg::CH_MINUS);
                    phase_next = dtoi_pkg::PH_SIGN;
                end
                else
                begin
                    phase_next = dtoi_pkg::PH_STOPPED;
                end
            end
            dtoi_pkg::PH_SIGN:
            begin
                if (is_digit)
                begin
                    found_next = 1'b1;
                    mag_next   = digit;
                    phase_next = dtoi_pkg::PH_DIGITS;
                end
                else
                begin
                    phase_next = dtoi_pkg::PH_STOPPED;
                end
            end
            dtoi_pkg::PH_DIGITS:
            begin
                if (!is_digit)
                begin
                    phase_next = dtoi_pkg::PH_STOPPED;
                end
                else if (overflow)
                begin
                    clamped_next = 1'b1;
                    phase_next   = dtoi_pkg::PH_STOPPED;
                end
                else
                begin
                    mag_next = mag_times_ten + digit;
                end
            end
            dtoi_pkg::PH_STOPPED:
            begin
                phase_next = dtoi_pkg::PH_STOPPED;
            end
            default:
            begin
                phase_next = dtoi_pkg::PH_STOPPED;
            end
        endcase
    end

    always_comb
    begin
        res_next.value   = '0;
        res_next.outcome = dtoi_pkg::OUT_NONE;
        if (found_next)
        begin
            if (clamped_next)
            begin
                res_next.value   = neg_next ? dtoi_pkg::INT_MIN_VAL : dtoi_pkg::INT_MAX_VAL;
                res_next.outcome = dtoi_pkg::OUT_CLAMPED;
            end
            else
            begin
                res_next.value   = neg_next ? (32'd0 - mag_next) : mag_next;
                res_next.outcome = dtoi_pkg::OUT_PARSED;
            end
        end
    end

    // last character of a string returns the parser to its idle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dtoi_pkg::PH_SPACES;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            clamped_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (word_in.is_last)
            begin
                phase_reg   <= dtoi_pkg::PH_SPACES;
                mag_reg     <= '0;
                neg_reg     <= 1'b0;
                clamped_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                mag_reg     <= mag_next;
                neg_reg     <= neg_next;
                clamped_reg <= clamped_next;
                found_reg   <= found_next;
            end
        end
    end

endmodule

### hdl/dtoi_checker.sv
// ----------------------------------------------------------------------------
// dtoi_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module dtoi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_is_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic [1:0]  out_outcome
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_outcome == dtoi_pkg::OUT_NONE) |-> (out_value == 32'd0))
        else $error("no-number result with nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_outcome == dtoi_pkg::OUT_CLAMPED) |->
            ((out_value == dtoi_pkg::INT_MAX_VAL) || (out_value == dtoi_pkg::INT_MIN_VAL)))
        else $error("clamped result not at a limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_is_last, 2))
        else $error("result word without a last character two cycles before");

endmodule

bind decimal_text_to_int_saturating_top dtoi_checker u_dtoi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (chars.valid),
    .in_ready    (chars.ready),
    .in_is_last  (chars.is_last),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_value   (results.value),
    .out_outcome (results.outcome)
);
